// ===== src/lljd_pkg.sv =====
// package for the least-load job dispatcher
// widths, reset values, status and function codes shared by the interfaces and the core
// no dependencies
package lljd_pkg;

  localparam int SLICE_W    = 27;
  localparam int COST_W     = 16;
  localparam int LOAD_OUT_W = 30;
  localparam int CFG_IDX_W  = 2;

  localparam int NUM_QUEUES_DEF      = 4;
  localparam int SLOTS_PER_QUEUE_DEF = 8;

  localparam logic [SLICE_W-1:0]    SLICE_MAX = SLICE_W'(100000000);
  localparam logic [LOAD_OUT_W-1:0] LOAD_MAX  = LOAD_OUT_W'(800000000);

  localparam logic [SLICE_W-1:0] SLICE_ONE_RST   = SLICE_W'(6000000);
  localparam logic [SLICE_W-1:0] SLICE_TWO_RST   = SLICE_W'(4000000);
  localparam logic [SLICE_W-1:0] SLICE_THREE_RST = SLICE_W'(2000000);
  localparam logic [COST_W-1:0]  ZERO_COST_RST   = COST_W'(999);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLICE_ONE   = 2'd0,
    CFG_SLICE_TWO   = 2'd1,
    CFG_SLICE_THREE = 2'd2,
    CFG_ZERO_COST   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    FUNC_SUBMIT   = 1'b0,
    FUNC_COMPLETE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    PRIO_ZERO  = 2'd0,
    PRIO_ONE   = 2'd1,
    PRIO_TWO   = 2'd2,
    PRIO_THREE = 2'd3
  } prio_e;

  typedef enum logic [1:0] {
    STAT_PLACED    = 2'd0,
    STAT_ALL_FULL  = 2'd1,
    STAT_FREED     = 2'd2,
    STAT_IDLE_SLOT = 2'd3
  } status_e;

endpackage

// ===== src/lljd_if.sv =====
// channel interfaces of the least-load job dispatcher: job word in, result word out
// depends on lljd_pkg
interface lljd_job_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [1:0] priority_req;
  logic [1:0] done_queue;
  logic [2:0] done_slot;

  modport source (output valid, func, priority_req, done_queue, done_slot, input ready);
  modport sink   (input valid, func, priority_req, done_queue, done_slot, output ready);
endinterface

interface lljd_res_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [1:0]                          chosen_queue;
  logic [2:0]                          chosen_slot;
  logic [lljd_pkg::SLICE_W-1:0]        given_slice;
  logic [lljd_pkg::LOAD_OUT_W-1:0]     winning_load;

  modport source (output valid, status, chosen_queue, chosen_slot, given_slice, winning_load,
                  input ready);
  modport sink   (input valid, status, chosen_queue, chosen_slot, given_slice, winning_load,
                  output ready);
endinterface

// ===== src/lljd_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module lljd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/least_load_job_dispatcher_core.sv =====
// Least-load job dispatcher. A submit word maps its priority to a time slice and walks every
// slot of every queue, one slot per cycle through the slice ram read port, summing each queue's
// load and keeping the least loaded queue that still has a free slot (lowest index on ties);
// the job then takes that queue's first free slot. A complete word frees the named slot.
// A submit walks the slots through the single slice ram read port, whose read data is
// registered, and then updates the slot state and result in a finish state; a complete goes
// straight to that finish state. One word is handled at a time; the result register holds a
// finished result until taken, and a new word is accepted meanwhile.
// depends on lljd_pkg, lljd_if, lljd_ram
module least_load_job_dispatcher_core #(
  parameter int NUM_QUEUES      = lljd_pkg::NUM_QUEUES_DEF,
  parameter int SLOTS_PER_QUEUE = lljd_pkg::SLOTS_PER_QUEUE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lljd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lljd_pkg::SLICE_W-1:0]       cfg_data_i,
  lljd_job_if.sink                           job_i,
  lljd_res_if.source                         res_o
);

  localparam int NS  = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int AW  = (NS > 1) ? $clog2(NS) : 1;
  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW  = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
  localparam int FW  = $clog2(SLOTS_PER_QUEUE + 1);
  localparam int LW  = (lljd_pkg::SLICE_W + SW > lljd_pkg::LOAD_OUT_W) ?
                       lljd_pkg::SLICE_W + SW : lljd_pkg::LOAD_OUT_W;
  localparam int SLW = lljd_pkg::SLICE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_e;

  state_e state_q;

  // configuration
  logic [SLW-1:0]                  slice_one_q, slice_two_q, slice_three_q;
  logic [lljd_pkg::COST_W-1:0]     cost_q;

  // latched word
  logic                            func_q;
  logic [SLW-1:0]                  slice_q;
  logic [1:0]                      dq_q;
  logic [2:0]                      ds_q;
  logic                            comp_ok_q;
  logic [AW-1:0]                   comp_addr_q;

  // walk
  logic [AW-1:0]                   rd_addr_q;
  logic                            issue_done_q;
  logic                            acc_vld_q;
  logic [AW-1:0]                   acc_addr_q;
  logic [SW-1:0]                   acc_slot_q;
  logic [QW-1:0]                   acc_queue_q;
  logic [LW-1:0]                   load_q;
  logic                            has_ff_q;
  logic [SW-1:0]                   ff_q;
  logic [AW-1:0]                   ff_addr_q;
  logic                            found_q;
  logic [LW-1:0]                   best_load_q;
  logic [QW-1:0]                   best_q;
  logic [SW-1:0]                   best_slot_q;
  logic [AW-1:0]                   best_addr_q;

  // slot state
  logic                            busy_q [NS];
  logic [FW-1:0]                   fill_q [NUM_QUEUES];

  // result register
  logic                            out_vld_q;
  logic [1:0]                      out_status_q;
  logic [1:0]                      out_queue_q;
  logic [2:0]                      out_slot_q;
  logic [SLW-1:0]                  out_slice_q;
  logic [lljd_pkg::LOAD_OUT_W-1:0] out_load_q;

  logic [SLW-1:0]                  rd_data;
  logic                            issuing;
  logic                            accept;
  logic                            out_free;
  logic                            acc_busy;
  logic [LW-1:0]                   add_val;
  logic [LW-1:0]                   load_sum;
  logic                            cur_free;
  logic [SW-1:0]                   ff_cur;
  logic [AW-1:0]                   ff_addr_cur;
  logic                            last_slot;
  logic                            q_full;
  logic                            better;
  logic                            ram_we;
  logic [SLW-1:0]                  map_raw;
  logic [SLW-1:0]                  map_slice;
  logic                            comp_hit;
  logic [QW-1:0]                   comp_q;
  logic [lljd_pkg::LOAD_OUT_W-1:0] load_sat;

  assign accept   = job_i.valid && job_i.ready;
  assign out_free = !out_vld_q || res_o.ready;
  assign issuing  = (state_q == S_WALK) && !issue_done_q;

  always_comb begin
    case (lljd_pkg::prio_e'(job_i.priority_req))
      lljd_pkg::PRIO_ONE:   map_raw = slice_one_q;
      lljd_pkg::PRIO_TWO:   map_raw = slice_two_q;
      lljd_pkg::PRIO_THREE: map_raw = slice_three_q;
      default:              map_raw = '0;
    endcase
    map_slice = (map_raw > lljd_pkg::SLICE_MAX) ? lljd_pkg::SLICE_MAX : map_raw;
  end

  // per-slot accumulate and queue compare
  assign acc_busy    = busy_q[acc_addr_q];
  assign add_val     = !acc_busy ? '0 :
                       (rd_data != '0) ? LW'(rd_data) : LW'(cost_q);
  assign load_sum    = load_q + add_val;
  assign cur_free    = !acc_busy && !has_ff_q;
  assign ff_cur      = has_ff_q ? ff_q : acc_slot_q;
  assign ff_addr_cur = has_ff_q ? ff_addr_q : acc_addr_q;
  assign last_slot   = (acc_slot_q == SW'(SLOTS_PER_QUEUE - 1));
  assign q_full      = (fill_q[acc_queue_q] == FW'(SLOTS_PER_QUEUE));
  assign better      = !q_full && (!found_q || (load_sum < best_load_q));

  assign ram_we   = (state_q == S_FIN) && out_free && (func_q == lljd_pkg::FUNC_SUBMIT) &&
                    found_q;
  assign comp_hit = comp_ok_q && busy_q[comp_addr_q];
  assign comp_q   = QW'(dq_q);
  assign load_sat = (best_load_q > LW'(lljd_pkg::LOAD_MAX)) ? lljd_pkg::LOAD_MAX :
                    lljd_pkg::LOAD_OUT_W'(best_load_q);

  lljd_ram #(
    .WIDTH (SLW),
    .DEPTH (NS)
  ) u_slice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (best_addr_q),
    .wdata_i (slice_q),
    .re_i    (issuing),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      slice_one_q   <= lljd_pkg::SLICE_ONE_RST;
      slice_two_q   <= lljd_pkg::SLICE_TWO_RST;
      slice_three_q <= lljd_pkg::SLICE_THREE_RST;
      cost_q        <= lljd_pkg::ZERO_COST_RST;
      func_q        <= lljd_pkg::FUNC_SUBMIT;
      slice_q       <= '0;
      dq_q          <= '0;
      ds_q          <= '0;
      comp_ok_q     <= 1'b0;
      comp_addr_q   <= '0;
      rd_addr_q     <= '0;
      issue_done_q  <= 1'b0;
      acc_vld_q     <= 1'b0;
      acc_addr_q    <= '0;
      acc_slot_q    <= '0;
      acc_queue_q   <= '0;
      load_q        <= '0;
      has_ff_q      <= 1'b0;
      ff_q          <= '0;
      ff_addr_q     <= '0;
      found_q       <= 1'b0;
      best_load_q   <= '0;
      best_q        <= '0;
      best_slot_q   <= '0;
      best_addr_q   <= '0;
      for (int i = 0; i < NS; i++) begin
        busy_q[i] <= 1'b0;
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fill_q[i] <= '0;
      end
      out_vld_q    <= 1'b0;
      out_status_q <= '0;
      out_queue_q  <= '0;
      out_slot_q   <= '0;
      out_slice_q  <= '0;
      out_load_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (lljd_pkg::cfg_idx_e'(cfg_idx_i))
          lljd_pkg::CFG_SLICE_ONE:   slice_one_q   <= cfg_data_i;
          lljd_pkg::CFG_SLICE_TWO:   slice_two_q   <= cfg_data_i;
          lljd_pkg::CFG_SLICE_THREE: slice_three_q <= cfg_data_i;
          lljd_pkg::CFG_ZERO_COST:   cost_q        <= cfg_data_i[lljd_pkg::COST_W-1:0];
          default: ;
        endcase
      end

      if (out_vld_q && res_o.ready) begin
        out_vld_q <= 1'b0;
      end

      acc_vld_q  <= issuing;
      acc_addr_q <= rd_addr_q;
      if (issuing) begin
        rd_addr_q <= rd_addr_q + AW'(1);
        if (rd_addr_q == AW'(NS - 1)) begin
          issue_done_q <= 1'b1;
        end
      end

      if (acc_vld_q) begin
        if (last_slot) begin
          if (better) begin
            found_q     <= 1'b1;
            best_load_q <= load_sum;
            best_q      <= acc_queue_q;
            best_slot_q <= ff_cur;
            best_addr_q <= ff_addr_cur;
          end
          load_q      <= '0;
          has_ff_q    <= 1'b0;
          acc_slot_q  <= '0;
          acc_queue_q <= acc_queue_q + QW'(1);
        end else begin
          load_q <= load_sum;
          if (cur_free) begin
            has_ff_q  <= 1'b1;
            ff_q      <= acc_slot_q;
            ff_addr_q <= acc_addr_q;
          end
          acc_slot_q <= acc_slot_q + SW'(1);
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            func_q      <= job_i.func;
            slice_q     <= map_slice;
            dq_q        <= job_i.done_queue;
            ds_q        <= job_i.done_slot;
            comp_ok_q   <= (int'(job_i.done_queue) < NUM_QUEUES) &&
                           (int'(job_i.done_slot) < SLOTS_PER_QUEUE);
            comp_addr_q <= AW'(int'(job_i.done_queue) * SLOTS_PER_QUEUE +
                               int'(job_i.done_slot));
            rd_addr_q    <= '0;
            issue_done_q <= 1'b0;
            acc_slot_q   <= '0;
            acc_queue_q  <= '0;
            load_q       <= '0;
            has_ff_q     <= 1'b0;
            found_q      <= 1'b0;
            if (job_i.func == lljd_pkg::FUNC_SUBMIT) begin
              state_q <= S_WALK;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_WALK: begin
          // last slot has been summed and compared
          if (acc_vld_q && (acc_addr_q == AW'(NS - 1))) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
            if (func_q == lljd_pkg::FUNC_SUBMIT) begin
              if (found_q) begin
                busy_q[best_addr_q] <= 1'b1;
                fill_q[best_q]      <= fill_q[best_q] + FW'(1);
                out_status_q        <= lljd_pkg::STAT_PLACED;
                out_queue_q         <= 2'(best_q);
                out_slot_q          <= 3'(best_slot_q);
                out_slice_q         <= slice_q;
                out_load_q          <= load_sat;
              end else begin
                out_status_q <= lljd_pkg::STAT_ALL_FULL;
                out_queue_q  <= '0;
                out_slot_q   <= '0;
                out_slice_q  <= '0;
                out_load_q   <= '0;
              end
            end else begin
              out_queue_q <= dq_q;
              out_slot_q  <= ds_q;
              out_slice_q <= '0;
              out_load_q  <= '0;
              if (comp_hit) begin
                busy_q[comp_addr_q] <= 1'b0;
                if (fill_q[comp_q] != '0) begin
                  fill_q[comp_q] <= fill_q[comp_q] - FW'(1);
                end
                out_status_q <= lljd_pkg::STAT_FREED;
              end else begin
                out_status_q <= lljd_pkg::STAT_IDLE_SLOT;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign job_i.ready        = (state_q == S_IDLE);
  assign res_o.valid        = out_vld_q;
  assign res_o.status       = out_status_q;
  assign res_o.chosen_queue = out_queue_q;
  assign res_o.chosen_slot  = out_slot_q;
  assign res_o.given_slice  = out_slice_q;
  assign res_o.winning_load = out_load_q;

endmodule
